/* sv/stq_pkg.sv */
// Package for the sorted timer queue: item structs, command and status codes,
// and the control and status structs between controller and datapath.
// No dependencies.
package stq_pkg;

  localparam int CMD_W    = 2;
  localparam int JOB_W    = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  // At most this many entries leave the queue on one tick.
  localparam int MAX_POPS = 16;
  localparam int POP_CW   = $clog2(MAX_POPS);

  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_SCHEDULED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [JOB_W-1:0]  job_id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    out_job;
    logic [TIME_W-1:0]   out_deadline;
    logic [OCC_W-1:0]    occupancy;
    logic                last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_req;
    logic                do_remove;
    logic                do_insert;
    logic                do_pop;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;
    logic full;
    logic due0;
    logic due1;
  } dp_status_t;

endpackage

/* sv/sorted_timer_queue_unit.sv */
// Sorted timer queue: a schedule runs a remove pass and then an insert pass
// over the cell chain, a cancel a remove step, and a tick pops one expired
// entry per cycle (up to 16) while the output is not stalled. The input
// stalls until a command's result is loaded; a waiting result stalls the next.
// Reset empties the queue (fill count cleared); entry cells are not cleared.
// Top level: instantiates stq_ctrl and stq_datapath; depends on stq_pkg.
module sorted_timer_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output stq_pkg::out_item_t out_data
);
  import stq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_st     (dp_st),
    .cmd       (cmd)
  );

  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .dp_st    (dp_st),
    .out_data (out_data)
  );

endmodule

/* sv/stq_ctrl.sv */
// Controller of the sorted timer queue: sequences remove, insert and pop
// steps and owns the handshake flags. Depends on stq_pkg.
module stq_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [stq_pkg::CMD_W-1:0] in_cmd,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  stq_pkg::dp_status_t     dp_st,
  output stq_pkg::ctrl_cmd_t      cmd
);
  import stq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REMOVE = 5'b00010,
    S_INSERT = 5'b00100,
    S_CANCEL = 5'b01000,
    S_POP    = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [POP_CW-1:0]   pop_cnt_r, pop_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                pop_last;

  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign pop_last  = (pop_cnt_r == POP_CW'(MAX_POPS - 1)) || !dp_st.due1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    pop_cnt_nxt = pop_cnt_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        pop_cnt_nxt = '0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          case (in_cmd)
            CMD_SCHEDULE: state_nxt = S_REMOVE;
            CMD_CANCEL:   state_nxt = S_CANCEL;
            CMD_TICK:     state_nxt = S_POP;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_REMOVE: begin
        // A reschedule drops the old entry before the insert.
        cmd.do_remove = 1'b1;
        state_nxt     = S_INSERT;
      end
      S_INSERT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          if (dp_st.full) begin
            cmd.out_status = ST_FULL;
          end else begin
            cmd.do_insert  = 1'b1;
            cmd.out_status = ST_SCHEDULED;
          end
          state_nxt = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (out_free) begin
          cmd.do_remove  = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = dp_st.found ? ST_CANCELLED : ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          if (dp_st.due0) begin
            cmd.do_pop     = 1'b1;
            cmd.out_status = ST_EXPIRED;
            cmd.out_last   = pop_last;
            pop_cnt_nxt    = pop_cnt_r + 1'b1;
            if (pop_last) begin
              state_nxt = S_IDLE;
            end
          end else begin
            // Only reached on the first step of a tick: nothing was due.
            cmd.out_status = ST_NOTHING;
            cmd.out_last   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pop_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop_cnt_r   <= pop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/stq_datapath.sv */
// Datapath of the sorted timer queue: a chain of entry cells that compare
// and shift in parallel, the fill count, the request and result registers.
// Depends on stq_pkg.
module stq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stq_pkg::in_item_t   in_data,
  input  stq_pkg::ctrl_cmd_t  cmd,
  output stq_pkg::dp_status_t dp_st,
  output stq_pkg::out_item_t  out_data
);
  import stq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [JOB_W-1:0]  ids_r [QUEUE_DEPTH];
  logic [JOB_W-1:0]  ids_nxt [QUEUE_DEPTH];
  logic [TIME_W-1:0] dls_r [QUEUE_DEPTH];
  logic [TIME_W-1:0] dls_nxt [QUEUE_DEPTH];
  logic [CW-1:0]     count_r, count_nxt;
  in_item_t          req_r;
  out_item_t         out_r, out_nxt;

  logic [QUEUE_DEPTH-1:0] in_use;
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH-1:0] le;
  logic [QUEUE_DEPTH-1:0] shift;

  // Per-cell compares. Entries are sorted, so le is a run of ones from the
  // head and the new entry goes into the first cell where it drops.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      in_use[i] = (CW'(i) < count_r);
      hit[i]    = in_use[i] && (ids_r[i] == req_r.job_id);
      le[i]     = in_use[i] && (dls_r[i] <= req_r.deadline);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      shift[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        shift[i] = shift[i] | hit[j];
      end
    end
  end

  assign dp_st.found = |hit;
  assign dp_st.full  = (count_r == CW'(QUEUE_DEPTH));
  assign dp_st.due0  = (count_r != '0) && (dls_r[0] <= req_r.now_time);
  assign dp_st.due1  = (count_r > CW'(1)) && (dls_r[1] <= req_r.now_time);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_nxt[i] = ids_r[i];
      dls_nxt[i] = dls_r[i];
    end
    // Removal and pop close the gap by moving later cells one place down.
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if ((cmd.do_remove && shift[i]) || cmd.do_pop) begin
        ids_nxt[i] = ids_r[i+1];
        dls_nxt[i] = dls_r[i+1];
      end
    end
    if (cmd.do_insert && !le[0]) begin
      ids_nxt[0] = req_r.job_id;
      dls_nxt[0] = req_r.deadline;
    end
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      if (cmd.do_insert && !le[i]) begin
        if (le[i-1]) begin
          ids_nxt[i] = req_r.job_id;
          dls_nxt[i] = req_r.deadline;
        end else begin
          ids_nxt[i] = ids_r[i-1];
          dls_nxt[i] = dls_r[i-1];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_remove && dp_st.found) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.do_pop) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.do_insert) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_comb begin
    out_nxt.status    = cmd.out_status;
    out_nxt.last      = cmd.out_last;
    out_nxt.occupancy = OCC_W'(count_nxt);
    case (cmd.out_status)
      ST_SCHEDULED, ST_FULL: begin
        out_nxt.out_job      = req_r.job_id;
        out_nxt.out_deadline = req_r.deadline;
      end
      ST_CANCELLED, ST_NOT_FOUND: begin
        out_nxt.out_job      = req_r.job_id;
        out_nxt.out_deadline = '0;
      end
      ST_EXPIRED: begin
        out_nxt.out_job      = ids_r[0];
        out_nxt.out_deadline = dls_r[0];
      end
      default: begin
        out_nxt.out_job      = '0;
        out_nxt.out_deadline = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_r[i] <= ids_nxt[i];
      dls_r[i] <= dls_nxt[i];
    end
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

/* sv/stq_checker.sv */
// Port-level checks for the sorted timer queue, bound to the top level.
// Depends on stq_pkg and sorted_timer_queue_unit.
module stq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input stq_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input stq_pkg::out_item_t out_data
);
  import stq_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Any real command that is taken makes the input side stall in the cycle after.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd != CMD_NONE) |=> in_stall)
    else $error("input taken again straight after a command");

  // Only expiry results can be followed by more results for the same item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_EXPIRED) |-> out_data.last)
    else $error("non-expiry result without last marker");

  // Occupancy never exceeds the queue depth (checked for depths up to 31).
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (QUEUE_DEPTH > 31) || (int'(out_data.occupancy) <= QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

endmodule

bind sorted_timer_queue_unit stq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_stq_checker (.*);
